// ===== src/command_frame_builder_crc16_defines.svh =====
// Assertion macros used by the datapath of the command frame builder.
`ifndef COMMAND_FRAME_BUILDER_CRC16_DEFINES_SVH
`define COMMAND_FRAME_BUILDER_CRC16_DEFINES_SVH

`ifndef ASSERT_OFF

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define CFB_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Whenever the antecedent holds, the consequent must hold in the next cycle.
`define CFB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define CFB_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define CFB_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/cfb_crc_pkg.sv =====
`default_nettype none

package cfb_crc_pkg;

  // Request kinds that carry a device byte.
  localparam logic [2:0] KIND_SINGLE_READ  = 3'd0;
  localparam logic [2:0] KIND_SINGLE_WRITE = 3'd1;

  // Result status codes.
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_DEV_HIGH = 2'd1;
  localparam logic [1:0] STAT_ZERO_LEN = 2'd2;
  localparam logic [1:0] STAT_LONG_LEN = 2'd3;

  // Byte select codes from the controller to the datapath.
  localparam logic [2:0] SEL_HDR  = 3'd0;
  localparam logic [2:0] SEL_DEV  = 3'd1;
  localparam logic [2:0] SEL_REGH = 3'd2;
  localparam logic [2:0] SEL_REGL = 3'd3;
  localparam logic [2:0] SEL_DATA = 3'd4;
  localparam logic [2:0] SEL_CRCL = 3'd5;
  localparam logic [2:0] SEL_CRCH = 3'd6;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  typedef struct packed {
    logic       load_req;
    logic       emit;
    logic [2:0] sel;
  } cfb_cmd_t;

  typedef struct packed {
    logic       out_free;
    logic       single;
    logic       data_last;
    logic [1:0] err;
  } cfb_stat_t;

  // One byte of the reflected CRC-16 update, bit by bit.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== src/cfb_crc_datapath.sv =====
`default_nettype none

`include "command_frame_builder_crc16_defines.svh"

module cfb_crc_datapath
  import cfb_crc_pkg::*;
#(
  parameter int MAX_DEVICE_ADDRESS = 63,
  parameter int MAX_PAYLOAD_BYTES  = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cfb_cmd_t    cmd,
  output cfb_stat_t        stat,
  input  wire logic [2:0]  in_request_kind,
  input  wire logic [7:0]  in_device_address,
  input  wire logic [15:0] in_register_address,
  input  wire logic [3:0]  in_payload_length,
  input  wire logic [63:0] in_payload_bytes,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_frame_byte,
  output logic             out_last_of_frame,
  output logic [1:0]       out_status
);

  localparam int PAY_W = 8 * MAX_PAYLOAD_BYTES;
  localparam int IDX_W = (MAX_PAYLOAD_BYTES > 1) ? $clog2(MAX_PAYLOAD_BYTES) : 1;

  logic [2:0]       kind_r;
  logic [7:0]       dev_r;
  logic [15:0]      reg_r;
  logic [3:0]       len_r;
  logic [PAY_W-1:0] pay_r;
  logic [15:0]      crc_r;
  logic [IDX_W-1:0] idx_r;

  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;
  logic [1:0] out_status_r;

  logic       single;
  logic [1:0] err;
  logic [7:0] byte_sel;
  logic       last_sel;

  // Request checks, in priority order.
  always_comb begin
    single = kind_r inside {KIND_SINGLE_READ, KIND_SINGLE_WRITE};
    if (single && (dev_r > 8'(MAX_DEVICE_ADDRESS))) begin
      err = STAT_DEV_HIGH;
    end else if (len_r == 4'd0) begin
      err = STAT_ZERO_LEN;
    end else if (len_r > 4'(MAX_PAYLOAD_BYTES)) begin
      err = STAT_LONG_LEN;
    end else begin
      err = STAT_OK;
    end
  end

  always_comb begin
    last_sel = 1'b0;
    case (cmd.sel)
      SEL_HDR: begin
        if (err != STAT_OK) begin
          byte_sel = 8'h00;
          last_sel = 1'b1;
        end else begin
          byte_sel = {1'b1, kind_r, 1'b0, 3'(len_r - 4'd1)};
        end
      end
      SEL_DEV:  byte_sel = dev_r;
      SEL_REGH: byte_sel = reg_r[15:8];
      SEL_REGL: byte_sel = reg_r[7:0];
      SEL_DATA: byte_sel = pay_r[8*idx_r +: 8];
      SEL_CRCL: byte_sel = crc_r[7:0];
      SEL_CRCH: begin
        byte_sel = crc_r[15:8];
        last_sel = 1'b1;
      end
      default:  byte_sel = 8'h00;
    endcase
  end

  assign stat.out_free  = !out_valid_r || out_ready;
  assign stat.single    = single;
  assign stat.data_last = ({{(4-IDX_W){1'b0}}, idx_r} == (len_r - 4'd1));
  assign stat.err       = err;

  // Request capture and running CRC. The CRC stays put while its own two bytes go out.
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      kind_r <= in_request_kind;
      dev_r  <= in_device_address;
      reg_r  <= in_register_address;
      len_r  <= in_payload_length;
      pay_r  <= in_payload_bytes[PAY_W-1:0];
      crc_r  <= CRC_INIT;
      idx_r  <= '0;
    end else if (cmd.emit) begin
      if (!(cmd.sel inside {SEL_CRCL, SEL_CRCH})) begin
        crc_r <= crc16_byte(crc_r, byte_sel);
      end
      if (cmd.sel == SEL_DATA) begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_byte_r   <= byte_sel;
      out_last_r   <= last_sel;
      out_status_r <= (cmd.sel == SEL_HDR) ? err : STAT_OK;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_frame_byte    = out_byte_r;
  assign out_last_of_frame = out_last_r;
  assign out_status        = out_status_r;

  `CFB_ASSERT_IMPLIES(a_emit_free, clk, rst_n, cmd.emit, !out_valid_r || out_ready)
  `CFB_ASSERT_NEXT(a_emit_valid, clk, rst_n, cmd.emit, out_valid_r)
  `CFB_ASSERT_IMPLIES(a_err_beat, clk, rst_n, out_valid_r && out_status_r != STAT_OK, out_last_r && out_byte_r == 8'h00)
  `CFB_ASSERT_IMPLIES(a_idx_range, clk, rst_n, cmd.emit && cmd.sel == SEL_DATA, {{(4-IDX_W){1'b0}}, idx_r} < len_r)

endmodule

`default_nettype wire

// ===== src/cfb_crc_ctrl.sv =====
`default_nettype none

module cfb_crc_ctrl
  import cfb_crc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire cfb_stat_t stat,
  output cfb_cmd_t       cmd
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_HDR  = 4'd1;
  localparam logic [3:0] ST_DEV  = 4'd2;
  localparam logic [3:0] ST_REGH = 4'd3;
  localparam logic [3:0] ST_REGL = 4'd4;
  localparam logic [3:0] ST_DATA = 4'd5;
  localparam logic [3:0] ST_CRCL = 4'd6;
  localparam logic [3:0] ST_CRCH = 4'd7;

  logic [3:0] state_r;
  logic [3:0] state_nxt;
  logic [2:0] sel;

  assign in_ready     = (state_r == ST_IDLE);
  assign cmd.load_req = in_valid && in_ready;
  assign cmd.emit     = (state_r != ST_IDLE) && stat.out_free;
  assign cmd.sel      = sel;

  always_comb begin
    state_nxt = state_r;
    sel       = SEL_HDR;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_HDR;
        end
      end
      ST_HDR: begin
        sel = SEL_HDR;
        if (stat.out_free) begin
          if (stat.err != STAT_OK) begin
            state_nxt = ST_IDLE;
          end else if (stat.single) begin
            state_nxt = ST_DEV;
          end else begin
            state_nxt = ST_REGH;
          end
        end
      end
      ST_DEV: begin
        sel = SEL_DEV;
        if (stat.out_free) begin
          state_nxt = ST_REGH;
        end
      end
      ST_REGH: begin
        sel = SEL_REGH;
        if (stat.out_free) begin
          state_nxt = ST_REGL;
        end
      end
      ST_REGL: begin
        sel = SEL_REGL;
        if (stat.out_free) begin
          state_nxt = ST_DATA;
        end
      end
      ST_DATA: begin
        sel = SEL_DATA;
        if (stat.out_free && stat.data_last) begin
          state_nxt = ST_CRCL;
        end
      end
      ST_CRCL: begin
        sel = SEL_CRCL;
        if (stat.out_free) begin
          state_nxt = ST_CRCH;
        end
      end
      ST_CRCH: begin
        sel = SEL_CRCH;
        if (stat.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/command_frame_builder_crc16.sv =====
// Command frame builder: one request beat in, one frame byte per output beat out. The frame
// is a header byte (bit 7 set, kind in 6:4, length minus one in 2:0), a device byte for the
// single-device kinds, the register address high byte first, the payload bytes in order and a
// CRC-16 (reflected polynomial A001, seeded with FFFF) low byte first; the last beat carries
// last_of_frame. A device address above MAX_DEVICE_ADDRESS on a single-device kind, a zero
// length or a length above MAX_PAYLOAD_BYTES yields a single zero beat with last_of_frame set
// and the error status instead. A request is captured while the controller is idle; the
// byte sequencer then produces one frame byte per cycle while the output register is free,
// folding every byte ahead of the two CRC bytes into the CRC. The next request is taken as
// soon as the final beat has been loaded into the output register, even if that beat is
// still waiting to be taken.
`default_nettype none

module command_frame_builder_crc16
  import cfb_crc_pkg::*;
#(
  parameter int MAX_DEVICE_ADDRESS = 63,
  parameter int MAX_PAYLOAD_BYTES  = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_request_kind,
  input  wire logic [7:0]  in_device_address,
  input  wire logic [15:0] in_register_address,
  input  wire logic [3:0]  in_payload_length,
  input  wire logic [63:0] in_payload_bytes,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_frame_byte,
  output logic             out_last_of_frame,
  output logic [1:0]       out_status
);

  cfb_cmd_t  cmd;
  cfb_stat_t stat;

  // The controller walks through the fields of the frame; it only advances when the
  // output register is free to take the next beat.
  cfb_crc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the captured request, the running CRC, the payload index and the
  // output register, and reports the request checks back to the controller.
  cfb_crc_datapath #(
    .MAX_DEVICE_ADDRESS (MAX_DEVICE_ADDRESS),
    .MAX_PAYLOAD_BYTES  (MAX_PAYLOAD_BYTES)
  ) u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .in_request_kind     (in_request_kind),
    .in_device_address   (in_device_address),
    .in_register_address (in_register_address),
    .in_payload_length   (in_payload_length),
    .in_payload_bytes    (in_payload_bytes),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_frame_byte      (out_frame_byte),
    .out_last_of_frame   (out_last_of_frame),
    .out_status          (out_status)
  );

endmodule

`default_nettype wire

// ===== sim/command_frame_builder_crc16_tb.sv =====
`default_nettype none

module command_frame_builder_crc16_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import cfb_crc_pkg::*;

  // Block parameters, kept at the values the block is built with.
  localparam int MAX_DEV = 63;
  localparam int MAX_LEN = 8;

  // Quiet cycles at the end, enough for any stray beat to show itself.
  localparam int DRAIN_CYCLES = 20;
  // The long output stall must outlast several whole frames so that the block fills up.
  localparam int LONG_HOLD_CYCLES = 150;
  // The slowest correct run is roughly 130 requests of 14 beats, each beat waiting out the
  // longest random output stall; the limit is far above that.
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_REQUESTS = 108;
  // From this request on neither side idles any more.
  localparam int STEADY_FROM = 85;
  // The long output stall is requested when the random part reaches this request.
  localparam int HOLD_AT = 20;

  // Request kinds as they appear in bits 6:4 of the header byte.
  typedef enum logic [2:0] {
    RK_SINGLE_READ,
    RK_SINGLE_WRITE,
    RK_STACK_READ,
    RK_STACK_WRITE,
    RK_BCAST_READ,
    RK_BCAST_WRITE,
    RK_BCAST_WRITE_REV,
    RK_RESERVED
  } request_kind_t;

  // One output beat as the block should present it.
  typedef struct {
    logic [7:0] data;
    logic       last;
    logic [1:0] status;
  } frame_beat_t;

  // The scoreboard works out the frame for every accepted request and checks each output
  // beat against the oldest beat still outstanding.
  class frame_scoreboard;
    frame_beat_t expected_beats[$];
    int failures;
    int requests;
    int frames_built;
    int refusals;
    int beats_checked;

    // CRC-16 with the reflected polynomial, fed one data bit at a time, least significant
    // bit first.
    static function logic [15:0] crc16_modbus_update(logic [15:0] crc, logic [7:0] data);
      logic [15:0] acc;
      logic        feedback;
      acc = crc;
      for (int i = 0; i < 8; i++) begin
        feedback = acc[0] ^ data[i];
        acc = acc >> 1;
        if (feedback) begin
          acc = acc ^ CRC_POLY;
        end
      end
      return acc;
    endfunction

    function void note_request(logic [2:0] kind, logic [7:0] dev, logic [15:0] regaddr,
                               logic [3:0] len, logic [63:0] payload);
      logic [7:0]  frame_bytes[$];
      logic [15:0] crc;
      logic [1:0]  refusal;
      logic        single;
      frame_beat_t beat;
      requests++;
      single = (kind == KIND_SINGLE_READ) || (kind == KIND_SINGLE_WRITE);
      // The checks are made in a fixed order and the first one that fails wins.
      refusal = STAT_OK;
      if (single && dev > MAX_DEV) begin
        refusal = STAT_DEV_HIGH;
      end else if (len == 0) begin
        refusal = STAT_ZERO_LEN;
      end else if (len > MAX_LEN) begin
        refusal = STAT_LONG_LEN;
      end
      if (refusal != STAT_OK) begin
        beat.data = 8'h00;
        beat.last = 1'b1;
        beat.status = refusal;
        expected_beats.push_back(beat);
        refusals++;
        return;
      end
      frame_bytes.push_back({1'b1, kind, 1'b0, 3'(len - 4'd1)});
      if (single) begin
        frame_bytes.push_back(dev);
      end
      frame_bytes.push_back(regaddr[15:8]);
      frame_bytes.push_back(regaddr[7:0]);
      for (int j = 0; j < len; j++) begin
        frame_bytes.push_back(payload[8*j +: 8]);
      end
      crc = CRC_INIT;
      foreach (frame_bytes[i]) begin
        crc = crc16_modbus_update(crc, frame_bytes[i]);
      end
      frame_bytes.push_back(crc[7:0]);
      frame_bytes.push_back(crc[15:8]);
      foreach (frame_bytes[i]) begin
        beat.data = frame_bytes[i];
        beat.last = (i == frame_bytes.size() - 1);
        beat.status = STAT_OK;
        expected_beats.push_back(beat);
      end
      frames_built++;
    endfunction

    function void check_beat(logic [7:0] data, logic last, logic [1:0] status);
      frame_beat_t want;
      beats_checked++;
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected beat data %h last %b status %0d", $time, data, last,
                 status);
        failures++;
        return;
      end
      want = expected_beats.pop_front();
      if (data !== want.data) begin
        $display("%0t: frame_byte expected %h actual %h", $time, want.data, data);
        failures++;
      end
      if (last !== want.last) begin
        $display("%0t: last_of_frame expected %b actual %b", $time, want.last, last);
        failures++;
      end
      if (status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, status);
        failures++;
      end
    endfunction

    function int outstanding();
      return expected_beats.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_request_kind;
  logic [7:0]  in_device_address;
  logic [15:0] in_register_address;
  logic [3:0]  in_payload_length;
  logic [63:0] in_payload_bytes;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_frame_byte;
  logic        out_last_of_frame;
  logic [1:0]  out_status;

  // The first two are shared between the request driver and the output side.
  logic hold_off_request;
  logic steady_tail;
  int   cycle_count;

  frame_scoreboard sb;

  command_frame_builder_crc16 #(
    .MAX_DEVICE_ADDRESS(MAX_DEV),
    .MAX_PAYLOAD_BYTES(MAX_LEN)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_request_kind(in_request_kind),
    .in_device_address(in_device_address),
    .in_register_address(in_register_address),
    .in_payload_length(in_payload_length),
    .in_payload_bytes(in_payload_bytes),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_frame_byte(out_frame_byte),
    .out_last_of_frame(out_last_of_frame),
    .out_status(out_status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Reset is held low from the start and released on a falling edge.
  initial begin
    rst_n = 1'b0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
  end

  // Handshakes are observed at the rising edge. The inputs only move on the falling edge,
  // so the values seen here are the ones the block registers at this edge. A request beat
  // is noted before the output beat is checked; an output at this edge can never belong to
  // a request taken at the same edge, so the order is harmless.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        sb.note_request(in_request_kind, in_device_address, in_register_address,
                        in_payload_length, in_payload_bytes);
      end
      if (out_valid && out_ready) begin
        sb.check_beat(out_frame_byte, out_last_of_frame, out_status);
      end
    end
  end

  // Runaway guard: if the run has not wound up by the limit, it has hung.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Run stopped after %0d cycles with %0d beats outstanding.", cycle_count,
             sb.outstanding());
    $display("== FAIL ==");
    $finish;
  end

  // Output side. Ready drops for random bursts, except in the steady tail of the run. Once,
  // on request from the driver, it stays low for a long stretch so that the block backs up
  // and has to refuse further request beats.
  initial begin
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        out_ready = 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        out_ready = 1'b1;
      end else if (!steady_tail && $urandom_range(0, 4) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
        out_ready = 1'b1;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // Offers one request beat, after an optional idle gap, and returns on the falling edge
  // after it has been taken. Valid stays high from one beat to the next when there is no
  // gap, so it is never lowered and raised within one time step.
  task automatic send_request(input logic [2:0] kind, input logic [7:0] dev,
                              input logic [15:0] regaddr, input logic [3:0] len,
                              input logic [63:0] payload, input int gap);
    if (gap > 0) begin
      in_valid = 1'b0;
      // The fields carry rubbish while valid is low; the block must not look at them.
      in_request_kind = 3'($urandom);
      in_device_address = 8'($urandom);
      in_payload_length = 4'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_request_kind = kind;
    in_device_address = dev;
    in_register_address = regaddr;
    in_payload_length = len;
    in_payload_bytes = payload;
    in_valid = 1'b1;
    do begin
      @(posedge clk);
    end while (!in_ready);
    @(negedge clk);
  endtask

  initial begin
    logic [2:0]  kind;
    logic [7:0]  dev;
    logic [3:0]  len;
    logic        single;
    int          gap;

    sb = new();
    hold_off_request = 1'b0;
    steady_tail = 1'b0;
    in_valid = 1'b0;
    in_request_kind = '0;
    in_device_address = '0;
    in_register_address = '0;
    in_payload_length = '0;
    in_payload_bytes = '0;
    wait (rst_n === 1'b1);
    @(negedge clk);

    // Directed part. Every kind once with a well-formed request, the reserved kind among
    // them, which must go out without a device byte.
    for (int k = 0; k < 8; k++) begin
      send_request(3'(k), 8'(k * 7), 16'($urandom), 4'(k + 1), {$urandom, $urandom}, 0);
    end
    // Device address at and just past the limit, and the extremes of the field.
    send_request(RK_SINGLE_READ, 8'(MAX_DEV), 16'h0000, 4'd1, 64'h0, 0);
    send_request(RK_SINGLE_WRITE, 8'(MAX_DEV + 1), 16'h1234, 4'd2, 64'hA5A5, 0);
    send_request(RK_SINGLE_READ, 8'hFF, 16'hFFFF, 4'd8, '1, 0);
    send_request(RK_SINGLE_WRITE, 8'h00, 16'hFFFF, 4'd8, '1, 0);
    // Broadcast and stack kinds do not check the device address at all.
    send_request(RK_BCAST_WRITE, 8'hFF, 16'h8001, 4'd4, {$urandom, $urandom}, 0);
    send_request(RK_STACK_READ, 8'h80, 16'h0000, 4'd1, 64'h0, 0);
    // Length errors, including a bad device that must take precedence over a bad length.
    send_request(RK_STACK_WRITE, 8'h00, 16'h00FF, 4'd0, '1, 0);
    send_request(RK_SINGLE_READ, 8'hC0, 16'h0100, 4'd0, 64'h0, 0);
    send_request(RK_BCAST_READ, 8'h10, 16'hFF00, 4'd9, '1, 0);
    send_request(RK_BCAST_WRITE_REV, 8'h01, 16'h5A5A, 4'd15, {$urandom, $urandom}, 0);
    send_request(RK_SINGLE_WRITE, 8'hFF, 16'h5A5A, 4'd15, 64'h0, 0);
    // Bytes beyond the length must be ignored, so fill them with rubbish.
    send_request(RK_SINGLE_WRITE, 8'd5, 16'hBEEF, 4'd3, 64'hFFFF_FFFF_FF00_0000, 0);
    send_request(RK_RESERVED, 8'hAA, 16'h7FFF, 4'd8, 64'h0123_4567_89AB_CDEF, 0);

    // Random part. Most requests are well formed with random content; about one in five
    // is plain noise across every field, which mostly ends up refused.
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i == HOLD_AT) begin
        hold_off_request = 1'b1;
      end
      if (i == STEADY_FROM) begin
        steady_tail = 1'b1;
      end
      gap = (steady_tail || $urandom_range(0, 3) != 0) ? 0 : $urandom_range(1, 9);
      kind = 3'($urandom_range(0, 7));
      single = (kind == KIND_SINGLE_READ) || (kind == KIND_SINGLE_WRITE);
      if ($urandom_range(0, 9) < 8) begin
        dev = single ? 8'($urandom_range(0, MAX_DEV)) : 8'($urandom_range(0, 255));
        len = 4'($urandom_range(1, MAX_LEN));
      end else begin
        dev = 8'($urandom_range(0, 255));
        len = 4'($urandom_range(0, 15));
      end
      send_request(kind, dev, 16'($urandom), len, {$urandom, $urandom}, gap);
    end
    in_valid = 1'b0;

    // Let every outstanding beat arrive, then watch for strays for a while.
    while (sb.outstanding() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests of every kind: %0d frames built, %0d refused.",
             sb.requests, sb.frames_built, sb.refusals);
    $display("Checked %0d output beats, with idle gaps on both sides and one long stall.",
             sb.beats_checked);
    if (sb.failures == 0 && sb.outstanding() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
